// ----- design/fser_pkg.sv -----
// ----------------------------------------------------------------------------
// fser_pkg
// Shared types and constants for the flash sector erase range block.
// ----------------------------------------------------------------------------
package fser_pkg;

   localparam int MAX_SECTORS = 256;
   localparam int IDX_W       = $clog2(MAX_SECTORS);
   localparam int CNT_W       = IDX_W + 1;
   localparam int ADDR_W      = 32;
   localparam int ESIZE_W     = 25;
   localparam int BLOCKS_W    = 9;
   localparam int FIRST_W     = 8;

   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_QUERY = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [ADDR_W-1:0] data;
   } tbl_wr_type;

   typedef struct packed {
      logic [ADDR_W:0]   cmp_a;
      logic [ADDR_W:0]   cmp_b;
      logic [ADDR_W-1:0] sub_b;
   } alu_in_type;

   typedef struct packed {
      logic              ge;
      logic [ADDR_W-1:0] diff;
   } alu_out_type;

endpackage

// ----- design/fser_if.sv -----
// ----------------------------------------------------------------------------
// fser channel interfaces
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fser_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [fser_pkg::ESIZE_W-1:0]  region_erase_size;
   logic [fser_pkg::BLOCKS_W-1:0] region_block_count;
   logic [fser_pkg::ADDR_W-1:0]   address;
   logic [fser_pkg::ADDR_W-1:0]   length;

   modport source (
      output valid, command, region_erase_size, region_block_count, address, length,
      input  ready
   );
   modport sink (
      input  valid, command, region_erase_size, region_block_count, address, length,
      output ready
   );
endinterface

interface fser_rsp_if;
   logic       valid;
   logic       ready;
   logic [fser_pkg::ADDR_W-1:0]  erase_length;
   logic [fser_pkg::FIRST_W-1:0] first_sector;
   logic [1:0] status;

   modport source (
      output valid, erase_length, first_sector, status,
      input  ready
   );
   modport sink (
      input  valid, erase_length, first_sector, status,
      output ready
   );
endinterface

interface fser_csr_if;
   logic       valid;
   logic       ready;
   logic [fser_pkg::ADDR_W-1:0] data;

   modport source (
      output valid, data,
      input  ready
   );
   modport sink (
      input  valid, data,
      output ready
   );
endinterface

// ----- design/fser_table.sv -----
// ----------------------------------------------------------------------------
// fser_table
// Sector start offset memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module fser_table (
   input  logic                            clock,
   input  fser_pkg::tbl_wr_type            wr,
   input  logic [fser_pkg::IDX_W-1:0]      rd_addr,
   output logic [fser_pkg::ADDR_W-1:0]     rd_data
);

   logic [fser_pkg::ADDR_W-1:0] sector_start_mem [fser_pkg::MAX_SECTORS];
   logic [fser_pkg::ADDR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         sector_start_mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= sector_start_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/fser_alu.sv -----
// ----------------------------------------------------------------------------
// fser_alu
// Shared compare and subtract unit used by the sequencer in its scan and check steps.
// ----------------------------------------------------------------------------
module fser_alu (
   input  fser_pkg::alu_in_type  alu_in,
   output fser_pkg::alu_out_type alu_out
);

   always_comb begin
      alu_out.ge   = (alu_in.cmp_a >= alu_in.cmp_b);
      alu_out.diff = alu_in.cmp_a[fser_pkg::ADDR_W-1:0] - alu_in.sub_b;
   end

endmodule

// ----- design/fser_seq.sv -----
// ----------------------------------------------------------------------------
// fser_seq
// Sequencer: appends regions, scans the sector table and forms erase spans.
// ----------------------------------------------------------------------------
module fser_seq (
   input  logic                        clock,
   input  logic                        reset,
   fser_req_if.sink                    req_chan,
   fser_rsp_if.source                  rsp_chan,
   fser_csr_if.sink                    csr_chan,
   output fser_pkg::tbl_wr_type        tbl_wr,
   output logic [fser_pkg::IDX_W-1:0]  tbl_rd_addr,
   input  logic [fser_pkg::ADDR_W-1:0] tbl_rd_data,
   output fser_pkg::alu_in_type        alu_in,
   input  fser_pkg::alu_out_type       alu_out
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD,
      S_LAST_RD,
      S_LAST_CAP,
      S_SCAN,
      S_CHK_LAST,
      S_CHK_SIZE,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [fser_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [fser_pkg::ADDR_W-1:0]   running_ff, running_in;
   logic [fser_pkg::ADDR_W-1:0]   flash_size_ff, flash_size_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          pend_ff, pend_in;
   logic                          phase_ff, phase_in;

   logic [fser_pkg::ESIZE_W-1:0]  esize_ff, esize_in;
   logic [fser_pkg::BLOCKS_W-1:0] left_ff, left_in;
   logic [fser_pkg::ADDR_W:0]     key_ff, key_in;
   logic [fser_pkg::ADDR_W:0]     end_ff, end_in;
   logic [fser_pkg::ADDR_W-1:0]   last_ff, last_in;
   logic [fser_pkg::ADDR_W-1:0]   start_ff, start_in;
   logic [fser_pkg::IDX_W-1:0]    first_ff, first_in;
   logic [fser_pkg::CNT_W-1:0]    rd_idx_ff, rd_idx_in;
   logic [fser_pkg::IDX_W-1:0]    pend_idx_ff, pend_idx_in;
   logic [fser_pkg::ADDR_W-1:0]   res_len_ff, res_len_in;
   logic [fser_pkg::FIRST_W-1:0]  res_first_ff, res_first_in;
   fser_pkg::status_type          res_status_ff, res_status_in;
   logic [fser_pkg::ADDR_W-1:0]   rsp_len_ff, rsp_len_in;
   logic [fser_pkg::FIRST_W-1:0]  rsp_first_ff, rsp_first_in;
   fser_pkg::status_type          rsp_status_ff, rsp_status_in;

   logic [fser_pkg::CNT_W-1:0]    last_idx;

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign csr_chan.ready        = 1'b1;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.erase_length = rsp_len_ff;
   assign rsp_chan.first_sector = rsp_first_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign last_idx              = count_ff - fser_pkg::CNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      running_in    = running_ff;
      flash_size_in = flash_size_ff;
      rsp_valid_in  = rsp_valid_ff;
      pend_in       = pend_ff;
      phase_in      = phase_ff;
      esize_in      = esize_ff;
      left_in       = left_ff;
      key_in        = key_ff;
      end_in        = end_ff;
      last_in       = last_ff;
      start_in      = start_ff;
      first_in      = first_ff;
      rd_idx_in     = rd_idx_ff;
      pend_idx_in   = pend_idx_ff;
      res_len_in    = res_len_ff;
      res_first_in  = res_first_ff;
      res_status_in = res_status_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_status_in = rsp_status_ff;

      tbl_wr        = '0;
      tbl_rd_addr   = rd_idx_ff[fser_pkg::IDX_W-1:0];
      alu_in.cmp_a  = {1'b0, tbl_rd_data};
      alu_in.cmp_b  = key_ff;
      alu_in.sub_b  = start_ff;

      if (csr_chan.valid) begin
         flash_size_in = csr_chan.data;
      end
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               esize_in      = req_chan.region_erase_size;
               left_in       = req_chan.region_block_count;
               key_in        = {1'b0, req_chan.address};
               end_in        = {1'b0, req_chan.address} + {1'b0, req_chan.length};
               res_len_in    = '0;
               res_first_in  = '0;
               res_status_in = fser_pkg::STATUS_OK;
               case (fser_pkg::cmd_type'(req_chan.command))
                  fser_pkg::CMD_ADD: begin
                     state_in = S_ADD;
                  end
                  fser_pkg::CMD_QUERY: begin
                     state_in = S_LAST_RD;
                  end
                  fser_pkg::CMD_CLEAR: begin
                     count_in   = '0;
                     running_in = '0;
                     state_in   = S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_ADD: begin
            if (left_ff == '0) begin
               state_in = S_DONE;
            end else if (count_ff == fser_pkg::CNT_W'(fser_pkg::MAX_SECTORS)) begin
               res_status_in = fser_pkg::STATUS_FULL;
               state_in      = S_DONE;
            end else begin
               tbl_wr.en   = 1'b1;
               tbl_wr.addr = count_ff[fser_pkg::IDX_W-1:0];
               tbl_wr.data = running_ff;
               count_in    = count_ff + fser_pkg::CNT_W'(1);
               running_in  = running_ff + fser_pkg::ADDR_W'(esize_ff);
               left_in     = left_ff - fser_pkg::BLOCKS_W'(1);
            end
         end
         S_LAST_RD: begin
            tbl_rd_addr = last_idx[fser_pkg::IDX_W-1:0];
            rd_idx_in   = '0;
            pend_in     = 1'b0;
            phase_in    = 1'b0;
            if (count_ff == '0) begin
               res_status_in = fser_pkg::STATUS_RANGE;
               state_in      = S_DONE;
            end else begin
               state_in = S_LAST_CAP;
            end
         end
         S_LAST_CAP: begin
            last_in  = tbl_rd_data;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (pend_ff && alu_out.ge) begin
               pend_in = 1'b0;
               if (!phase_ff) begin
                  first_in = pend_idx_ff;
                  start_in = tbl_rd_data;
                  state_in = S_CHK_LAST;
               end else begin
                  res_len_in   = alu_out.diff;
                  res_first_in = fser_pkg::FIRST_W'(first_ff);
                  state_in     = S_DONE;
               end
            end else if (rd_idx_ff < count_ff) begin
               pend_in     = 1'b1;
               pend_idx_in = rd_idx_ff[fser_pkg::IDX_W-1:0];
               rd_idx_in   = rd_idx_ff + fser_pkg::CNT_W'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  res_status_in = fser_pkg::STATUS_RANGE;
                  state_in      = S_DONE;
               end
            end
         end
         S_CHK_LAST: begin
            alu_in.cmp_a = {1'b0, last_ff};
            alu_in.cmp_b = end_ff;
            if (alu_out.ge) begin
               key_in    = end_ff;
               rd_idx_in = '0;
               pend_in   = 1'b0;
               phase_in  = 1'b1;
               state_in  = S_SCAN;
            end else begin
               state_in = S_CHK_SIZE;
            end
         end
         S_CHK_SIZE: begin
            alu_in.cmp_a = {1'b0, flash_size_ff};
            alu_in.cmp_b = end_ff;
            if (alu_out.ge) begin
               res_len_in   = alu_out.diff;
               res_first_in = fser_pkg::FIRST_W'(first_ff);
               state_in     = S_DONE;
            end else begin
               key_in    = end_ff;
               rd_idx_in = '0;
               pend_in   = 1'b0;
               phase_in  = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_len_in    = res_len_ff;
               rsp_first_in  = res_first_ff;
               rsp_status_in = res_status_ff;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         running_ff    <= '0;
         flash_size_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_ff       <= 1'b0;
         phase_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         running_ff    <= running_in;
         flash_size_ff <= flash_size_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_ff       <= pend_in;
         phase_ff      <= phase_in;
      end
      esize_ff      <= esize_in;
      left_ff       <= left_in;
      key_ff        <= key_in;
      end_ff        <= end_in;
      last_ff       <= last_in;
      start_ff      <= start_in;
      first_ff      <= first_in;
      rd_idx_ff     <= rd_idx_in;
      pend_idx_ff   <= pend_idx_in;
      res_len_ff    <= res_len_in;
      res_first_ff  <= res_first_in;
      res_status_ff <= res_status_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

// ----- design/flash_sector_erase_range_top.sv -----
// ----------------------------------------------------------------------------
// flash_sector_erase_range_top
// Sector start table with region append and erase span lookup.
// ----------------------------------------------------------------------------
// add region: one table write per cycle until block_count entries are added or the table is full
// erase query: one table read and compare per cycle while scanning for the span start and end
// clear or unused command: no table access; every command also waits for the output register
// one word in flight, next word taken in the cycle after the response register loads
// reset clears entry count, running offset and flash_size; table contents are kept
module flash_sector_erase_range_top (
   input  logic        clock,
   input  logic        reset,
   fser_req_if.sink    req_chan,
   fser_rsp_if.source  rsp_chan,
   fser_csr_if.sink    csr_chan
);

   fser_pkg::tbl_wr_type        tbl_wr;
   logic [fser_pkg::IDX_W-1:0]  tbl_rd_addr;
   logic [fser_pkg::ADDR_W-1:0] tbl_rd_data;
   fser_pkg::alu_in_type        alu_in;
   fser_pkg::alu_out_type       alu_out;

   fser_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_chan    (csr_chan),
      .tbl_wr      (tbl_wr),
      .tbl_rd_addr (tbl_rd_addr),
      .tbl_rd_data (tbl_rd_data),
      .alu_in      (alu_in),
      .alu_out     (alu_out)
   );

   fser_table u_table (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   fser_alu u_alu (
      .alu_in  (alu_in),
      .alu_out (alu_out)
   );

endmodule

// ----- tb/flash_sector_erase_range_top_tb.sv -----
// ----------------------------------------------------------------------------
// flash_sector_erase_range_top_tb
// Drives region adds, erase span queries, table clears and unused commands
// into the block and checks every response word against a behavioral
// sector table kept in the bench. flash_size is rewritten between phases
// of different flow-control pressure, including a long response hold-off.
// ----------------------------------------------------------------------------
module flash_sector_erase_range_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_IGNORED = 2'd3;
   localparam int unsigned ESIZE_MAX  = 16777216;

   typedef struct packed {
      logic [1:0]                    command;
      logic [fser_pkg::ESIZE_W-1:0]  erase_size;
      logic [fser_pkg::BLOCKS_W-1:0] block_count;
      logic [fser_pkg::ADDR_W-1:0]   address;
      logic [fser_pkg::ADDR_W-1:0]   length;
   } erase_req_type;

   typedef struct packed {
      logic [fser_pkg::ADDR_W-1:0]  erase_length;
      logic [fser_pkg::FIRST_W-1:0] first_sector;
      logic [1:0]                   status;
   } erase_rsp_type;

   logic clock;
   logic reset;

   fser_req_if req_chan ();
   fser_rsp_if rsp_chan ();
   fser_csr_if csr_chan ();

   flash_sector_erase_range_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // bench copy of the sector table
   logic [fser_pkg::ADDR_W-1:0] sector_starts [fser_pkg::MAX_SECTORS];
   int unsigned                 sectors_used = 0;
   logic [fser_pkg::ADDR_W-1:0] next_start   = '0;
   logic [fser_pkg::ADDR_W-1:0] flash_bytes  = '0;

   // generator view of the table, used only to aim queries
   logic [fser_pkg::ADDR_W-1:0] gen_starts [$];
   logic [fser_pkg::ADDR_W-1:0] gen_next = '0;

   erase_req_type pending_words [$];
   erase_rsp_type expected_spans [$];
   erase_req_type word_on_bus;
   int unsigned   send_idle_pct = 0;
   int unsigned   rsp_stall_pct = 0;
   int unsigned   mismatch_count = 0;
   logic          rsp_hold = 1'b0;
   bit            hold_go = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int unsigned first_at_or_after(input logic [fser_pkg::ADDR_W:0] key);
      for (int unsigned i = 0; i < sectors_used; i++) begin
         if ({1'b0, sector_starts[i]} >= key) return i;
      end
      return sectors_used;
   endfunction

   function automatic erase_rsp_type predict_span(input erase_req_type w);
      erase_rsp_type             o;
      logic [fser_pkg::ADDR_W:0] span_end;
      int unsigned               first_idx;
      int unsigned               end_idx;
      o = '0;
      case (w.command)
         fser_pkg::CMD_ADD: begin
            for (int j = 0; j < w.block_count; j++) begin
               if (sectors_used >= fser_pkg::MAX_SECTORS) begin
                  o.status = fser_pkg::STATUS_FULL;
                  break;
               end
               sector_starts[sectors_used] = next_start;
               sectors_used++;
               next_start = next_start + fser_pkg::ADDR_W'(w.erase_size);
            end
         end
         fser_pkg::CMD_QUERY: begin
            span_end = {1'b0, w.address} + {1'b0, w.length};
            first_idx = first_at_or_after({1'b0, w.address});
            if (first_idx >= sectors_used) begin
               o.status = fser_pkg::STATUS_RANGE;
            end else if (span_end > {1'b0, sector_starts[sectors_used-1]} &&
                         span_end <= {1'b0, flash_bytes}) begin
               o.erase_length = flash_bytes - sector_starts[first_idx];
               o.first_sector = fser_pkg::FIRST_W'(first_idx);
            end else begin
               end_idx = first_at_or_after(span_end);
               if (end_idx >= sectors_used) begin
                  o.status = fser_pkg::STATUS_RANGE;
               end else begin
                  o.erase_length = sector_starts[end_idx] - sector_starts[first_idx];
                  o.first_sector = fser_pkg::FIRST_W'(first_idx);
               end
            end
         end
         fser_pkg::CMD_CLEAR: begin
            sectors_used = 0;
            next_start = '0;
         end
         default: ;
      endcase
      return o;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.command <= '0;
         req_chan.region_erase_size <= '0;
         req_chan.region_block_count <= '0;
         req_chan.address <= '0;
         req_chan.length <= '0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_spans.push_back(predict_span(word_on_bus));
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               word_on_bus = pending_words.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.command <= word_on_bus.command;
               req_chan.region_erase_size <= word_on_bus.erase_size;
               req_chan.region_block_count <= word_on_bus.block_count;
               req_chan.address <= word_on_bus.address;
               req_chan.length <= word_on_bus.length;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      erase_rsp_type exp_word;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_spans.size() == 0) begin
               $error("unexpected response word: erase_length %0h first_sector %0d status %0d",
                      rsp_chan.erase_length, rsp_chan.first_sector, rsp_chan.status);
               mismatch_count++;
            end else begin
               exp_word = expected_spans.pop_front();
               if (rsp_chan.erase_length !== exp_word.erase_length) begin
                  $error("erase_length mismatch: expected %0h actual %0h",
                         exp_word.erase_length, rsp_chan.erase_length);
                  mismatch_count++;
               end
               if (rsp_chan.first_sector !== exp_word.first_sector) begin
                  $error("first_sector mismatch: expected %0d actual %0d",
                         exp_word.first_sector, rsp_chan.first_sector);
                  mismatch_count++;
               end
               if (rsp_chan.status !== exp_word.status) begin
                  $error("status mismatch: expected %0d actual %0d",
                         exp_word.status, rsp_chan.status);
                  mismatch_count++;
               end
            end
         end
         rsp_chan.ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // long response hold-off
   initial begin
      wait (hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (400) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #10_000_000;
      $display("flash_sector_erase_range_top verification failed");
      $finish;
   end

   function automatic erase_req_type make_word(input logic [1:0] command,
                                               input int unsigned esize,
                                               input int unsigned count,
                                               input logic [fser_pkg::ADDR_W-1:0] address,
                                               input logic [fser_pkg::ADDR_W-1:0] length);
      erase_req_type w;
      w.command = command;
      w.erase_size = fser_pkg::ESIZE_W'(esize);
      w.block_count = fser_pkg::BLOCKS_W'(count);
      w.address = address;
      w.length = length;
      return w;
   endfunction

   function automatic erase_req_type random_fields();
      return make_word(2'($urandom_range(3)), $urandom_range(0, ESIZE_MAX),
                       $urandom_range(0, fser_pkg::MAX_SECTORS), $urandom, $urandom);
   endfunction

   function automatic void queue_word(input erase_req_type w);
      pending_words.push_back(w);
      if (w.command == fser_pkg::CMD_CLEAR) begin
         gen_starts.delete();
         gen_next = '0;
      end else if (w.command == fser_pkg::CMD_ADD) begin
         for (int j = 0; j < w.block_count; j++) begin
            if (gen_starts.size() < fser_pkg::MAX_SECTORS) begin
               gen_starts.push_back(gen_next);
               gen_next = gen_next + fser_pkg::ADDR_W'(w.erase_size);
            end
         end
      end
   endfunction

   function automatic erase_req_type random_region();
      erase_req_type w;
      w = random_fields();
      w.command = fser_pkg::CMD_ADD;
      w.block_count = ($urandom_range(29) == 0) ?
                      fser_pkg::BLOCKS_W'($urandom_range(0, fser_pkg::MAX_SECTORS)) :
                      fser_pkg::BLOCKS_W'($urandom_range(1, 8));
      case ($urandom_range(3))
         0: w.erase_size = fser_pkg::ESIZE_W'(1) << $urandom_range(9, 16);
         1: w.erase_size = fser_pkg::ESIZE_W'($urandom_range(0, 65536));
         2: w.erase_size = fser_pkg::ESIZE_W'($urandom_range(0, ESIZE_MAX));
         default: w.erase_size = fser_pkg::ESIZE_W'(1) << $urandom_range(0, 24);
      endcase
      return w;
   endfunction

   function automatic erase_req_type random_query();
      erase_req_type               w;
      logic [fser_pkg::ADDR_W-1:0] base;
      logic [fser_pkg::ADDR_W-1:0] other;
      w = random_fields();
      w.command = fser_pkg::CMD_QUERY;
      if (gen_starts.size() != 0) begin
         base = gen_starts[$urandom_range(gen_starts.size() - 1)];
         other = gen_starts[$urandom_range(gen_starts.size() - 1)];
      end else begin
         base = $urandom;
         other = $urandom;
      end
      case ($urandom_range(3))
         0: w.address = base;
         1: w.address = base + $urandom_range(1, 4095) - 2048;
         2: w.address = $urandom_range(0, gen_next);
         default: w.address = $urandom;
      endcase
      case ($urandom_range(4))
         0: w.length = other - w.address;
         1: w.length = $urandom_range(0, 65536);
         2: w.length = flash_bytes - w.address - $urandom_range(0, 1);
         3: w.length = gen_next - w.address + $urandom_range(0, 3);
         default: w.length = $urandom;
      endcase
      return w;
   endfunction

   task automatic queue_random_words(input int unsigned target);
      int unsigned   counted;
      erase_req_type w;
      counted = 0;
      while (counted < target) begin
         if ($urandom_range(19) == 0) begin
            w = random_fields();
            queue_word(w);
            if (w.command != CMD_IGNORED) counted++;
         end else begin
            if ($urandom_range(4) != 0) begin
               w = random_fields();
               w.command = fser_pkg::CMD_CLEAR;
               queue_word(w);
               counted++;
            end
            repeat ($urandom_range(1, 3)) begin
               queue_word(random_region());
               counted++;
            end
            repeat ($urandom_range(2, 8)) begin
               queue_word(random_query());
               counted++;
            end
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0 || req_chan.valid || expected_spans.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_flash_size(input logic [fser_pkg::ADDR_W-1:0] value);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.data <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      flash_bytes = value;
      @(negedge clock);
   endtask

   initial begin
      reset = 1'b1;
      csr_chan.valid = 1'b0;
      csr_chan.data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed words
      write_flash_size(32'h0100_0000);
      queue_word(make_word(fser_pkg::CMD_QUERY, 0, 0, 32'h0, 32'h10));
      queue_word(make_word(fser_pkg::CMD_ADD, 32'h1000, 4, 32'h0, 32'h0));
      queue_word(make_word(fser_pkg::CMD_ADD, 32'h10000, 2, 32'h0, 32'h0));
      queue_word(make_word(fser_pkg::CMD_QUERY, 0, 0, 32'h0, 32'h1000));
      queue_word(make_word(fser_pkg::CMD_QUERY, 0, 0, 32'h1001, 32'h100));
      queue_word(make_word(fser_pkg::CMD_QUERY, 0, 0, 32'h14000, 32'h10));
      queue_word(make_word(fser_pkg::CMD_QUERY, 0, 0, 32'h14001, 32'h10));
      queue_word(make_word(fser_pkg::CMD_QUERY, 0, 0, 32'h0, 32'h0100_0000));
      queue_word(make_word(fser_pkg::CMD_QUERY, 0, 0, 32'h0, 32'h0100_0001));
      queue_word(make_word(fser_pkg::CMD_QUERY, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      queue_word(make_word(fser_pkg::CMD_QUERY, 0, 0, 32'h0, 32'hFFFF_FFFF));
      queue_word(make_word(CMD_IGNORED, ESIZE_MAX, fser_pkg::MAX_SECTORS,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF));
      queue_word(make_word(fser_pkg::CMD_CLEAR, 0, 0, 32'h0, 32'h0));
      queue_word(make_word(fser_pkg::CMD_ADD, 0, 0, 32'h0, 32'h0));
      queue_word(make_word(fser_pkg::CMD_ADD, ESIZE_MAX, fser_pkg::MAX_SECTORS, 32'h0, 32'h0));
      queue_word(make_word(fser_pkg::CMD_ADD, 1, 1, 32'h0, 32'h0));
      queue_word(make_word(fser_pkg::CMD_QUERY, 0, 0, 32'h0, 32'h0));
      queue_word(make_word(fser_pkg::CMD_QUERY, 0, 0, 32'hFF00_0000, 32'h0));
      queue_word(make_word(fser_pkg::CMD_QUERY, 0, 0, 32'h1234_5678, 32'h100));
      queue_word(make_word(fser_pkg::CMD_CLEAR, 0, 0, 32'h0, 32'h0));
      queue_word(make_word(fser_pkg::CMD_ADD, 32'hFF_FFFF, 255, 32'h0, 32'h0));
      queue_word(make_word(fser_pkg::CMD_ADD, 32'h1000, 2, 32'h0, 32'h0));
      queue_word(make_word(fser_pkg::CMD_QUERY, 0, 0, 32'h0, 32'h1));
      queue_word(make_word(fser_pkg::CMD_CLEAR, 0, 0, 32'h0, 32'h0));
      wait_drained();

      // no idling, largest flash
      write_flash_size(32'hFFFF_FFFF);
      queue_random_words(300);
      wait_drained();

      // sender mostly idle, zero flash size
      send_idle_pct = 88;
      write_flash_size(32'h0);
      queue_random_words(300);
      wait_drained();

      // receiver mostly stalled
      send_idle_pct = 0;
      rsp_stall_pct = 88;
      write_flash_size(32'h0100_0000);
      queue_random_words(300);
      wait_drained();

      // both sides idle now and then
      send_idle_pct = 26;
      rsp_stall_pct = 26;
      write_flash_size($urandom);
      queue_random_words(300);
      wait_drained();

      // receiver held off while requests keep coming
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      write_flash_size($urandom_range(0, 32'h0080_0000));
      hold_go = 1'b1;
      queue_random_words(60);
      wait_drained();

      repeat (600) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("flash_sector_erase_range_top verification clean");
      end else begin
         $display("flash_sector_erase_range_top verification failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/fser_pkg.sv
design/fser_if.sv
design/fser_table.sv
design/fser_alu.sv
design/fser_seq.sv
design/flash_sector_erase_range_top.sv
tb/flash_sector_erase_range_top_tb.sv
